// ----- src/md4_pkg.sv -----
// ----------------------------------------------------------------------------
// md4_pkg
// Shared constants, command struct and round helper functions for the MD4
// block compressor.
// ----------------------------------------------------------------------------
package md4_pkg;

	// initial chaining values
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	// added constants of the second and third round
	localparam logic [31:0] K2 = 32'h5a827999;
	localparam logic [31:0] K3 = 32'h6ed9eba1;

	// round groups
	localparam logic [1:0] RND_F = 2'd0;
	localparam logic [1:0] RND_G = 2'd1;
	localparam logic [1:0] RND_H = 2'd2;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned NUM_STEPS = 48;
	localparam logic [5:0] LAST_STEP = 6'(NUM_STEPS - 1);
	localparam logic [3:0] LAST_SLOT = 4'(BLOCK_WORDS - 1);
	localparam logic [1:0] LAST_OUT = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic       load_iv;
		logic       wr_word;
		logic [3:0] wr_slot;
		logic       init_work;
		logic       step_en;
		logic [5:0] step_idx;
		logic       fold;
		logic       capture;
		logic [1:0] out_sel;
	} md4_cmd_t;

	// message word used by a step
	function automatic logic [3:0] msg_index(input logic [1:0] rnd, input logic [3:0] i);
		logic [3:0] idx;
		unique case (rnd)
			RND_F:   idx = i;
			RND_G:   idx = {i[1:0], i[3:2]};
			RND_H:   idx = {i[0], i[1], i[2], i[3]};
			default: idx = i;
		endcase
		return idx;
	endfunction

	// rotation amount of a step
	function automatic logic [4:0] rot_amt(input logic [1:0] rnd, input logic [1:0] j);
		logic [4:0] s;
		unique case ({rnd, j})
			{RND_F, 2'd0}: s = 5'd3;
			{RND_F, 2'd1}: s = 5'd7;
			{RND_F, 2'd2}: s = 5'd11;
			{RND_F, 2'd3}: s = 5'd19;
			{RND_G, 2'd0}: s = 5'd3;
			{RND_G, 2'd1}: s = 5'd5;
			{RND_G, 2'd2}: s = 5'd9;
			{RND_G, 2'd3}: s = 5'd13;
			{RND_H, 2'd0}: s = 5'd3;
			{RND_H, 2'd1}: s = 5'd9;
			{RND_H, 2'd2}: s = 5'd11;
			{RND_H, 2'd3}: s = 5'd15;
			default:       s = 5'd3;
		endcase
		return s;
	endfunction

	// added constant of a round
	function automatic logic [31:0] round_k(input logic [1:0] rnd);
		logic [31:0] k;
		unique case (rnd)
			RND_F:   k = 32'd0;
			RND_G:   k = K2;
			RND_H:   k = K3;
			default: k = 32'd0;
		endcase
		return k;
	endfunction

	// boolean function of a round
	function automatic logic [31:0] round_f(input logic [1:0] rnd, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		logic [31:0] f;
		unique case (rnd)
			RND_F:   f = z ^ (x & (y ^ z));
			RND_G:   f = (x & y) | (x & z) | (y & z);
			RND_H:   f = x ^ y ^ z;
			default: f = x ^ y ^ z;
		endcase
		return f;
	endfunction

endpackage

// ----- src/md4_dp.sv -----
// ----------------------------------------------------------------------------
// md4_dp
// Datapath: block buffer, chaining words, working registers with one MD4
// step per cycle, and the digest output buffer.
// ----------------------------------------------------------------------------
module md4_dp import md4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  md4_cmd_t    cmd,
	input  logic [31:0] message_word,
	output logic [31:0] digest_word
);

	logic [31:0] blk_q [BLOCK_WORDS];
	logic [31:0] chain_q [4];
	logic [31:0] out_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;

	logic [1:0]  rnd;
	logic [3:0]  sub;
	logic [4:0]  s;
	logic [31:0] x;
	logic [31:0] sum;
	logic [31:0] rot;
	logic [31:0] new_w [4];

	// step operands
	assign rnd = cmd.step_idx[5:4];
	assign sub = cmd.step_idx[3:0];
	assign s   = rot_amt(rnd, sub[1:0]);
	assign x   = blk_q[msg_index(rnd, sub)];
	assign sum = a_q + round_f(rnd, b_q, c_q, d_q) + x + round_k(rnd);
	assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

	// chaining words after the feed-forward add
	assign new_w[0] = chain_q[0] + a_q;
	assign new_w[1] = chain_q[1] + b_q;
	assign new_w[2] = chain_q[2] + c_q;
	assign new_w[3] = chain_q[3] + d_q;

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
		end else if (cmd.load_iv) begin
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
		end else if (cmd.fold) begin
			for (int k = 0; k < 4; k++) chain_q[k] <= new_w[k];
		end
	end

	// block buffer
	always_ff @(posedge clk) begin
		if (cmd.wr_word) blk_q[cmd.wr_slot] <= message_word;
	end

	// working registers, rotated so the target is always in a
	always_ff @(posedge clk) begin
		if (cmd.init_work) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (cmd.step_en) begin
			a_q <= d_q;
			b_q <= rot;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	// digest buffer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int k = 0; k < 4; k++) out_q[k] <= new_w[k];
		end
	end

	assign digest_word = out_q[cmd.out_sel];

endmodule

// ----- src/md4_ctrl.sv -----
// ----------------------------------------------------------------------------
// md4_ctrl
// Controller: word position, step counter, compression sequence and the
// digest output handshake.
// ----------------------------------------------------------------------------
module md4_ctrl import md4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       start_of_message,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] word_index,
	output logic       last_word,
	output md4_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FOLD
	} state_t;

	state_t     state_q;
	logic [3:0] pos_q;
	logic [5:0] step_q;
	logic       end_q;
	logic       out_valid_q;
	logic [1:0] out_idx_q;

	logic       in_acc;
	logic       out_acc;
	logic [3:0] slot;
	logic       blk_done;

	// input side
	assign in_ready = (state_q == ST_IDLE) && !(out_valid_q && pos_q == LAST_SLOT);
	assign in_acc   = in_valid && in_ready;
	assign slot     = start_of_message ? 4'd0 : pos_q;
	assign blk_done = slot == LAST_SLOT;
	assign out_acc  = out_valid_q && out_ready;

	// commands
	always_comb begin
		cmd           = '0;
		cmd.load_iv   = in_acc && start_of_message;
		cmd.wr_word   = in_acc;
		cmd.wr_slot   = slot;
		cmd.init_work = in_acc && blk_done;
		cmd.step_en   = state_q == ST_STEP;
		cmd.step_idx  = step_q;
		cmd.fold      = state_q == ST_FOLD;
		cmd.capture   = (state_q == ST_FOLD) && end_q;
		cmd.out_sel   = out_idx_q;
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			step_q      <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pos_q <= slot + 4'd1;
						if (blk_done) begin
							end_q   <= end_of_message;
							step_q  <= '0;
							state_q <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					step_q <= step_q + 6'd1;
					if (step_q == LAST_STEP) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (end_q) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_acc) begin
				out_idx_q <= out_idx_q + 2'd1;
				if (out_idx_q == LAST_OUT) out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign word_index = out_idx_q;
	assign last_word  = out_idx_q == LAST_OUT;

	// digest buffer is never overwritten while it is being drained
	a_fold_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FOLD |-> !out_valid_q)
		else $error("fold while digest pending");

	// step counter stays inside the three rounds
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> step_q <= LAST_STEP)
		else $error("step counter out of range");

	// a completed block starts the step sequence
	a_blk_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && blk_done |=> state_q == ST_STEP && step_q == 6'd0)
		else $error("block did not start compression");

	// digest appears only after a fold
	a_out_after_fold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FOLD) && out_idx_q == 2'd0)
		else $error("digest without fold");

endmodule

// ----- src/md4_block_compressor_unit.sv -----
// ----------------------------------------------------------------------------
// md4_block_compressor_unit
// MD4 block compressor: collects 16 padded message words, runs the 48 MD4
// steps and emits the four digest words after the final block.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | in_valid, in_ready  | message_word, start_of_message, end_of_message
//  output  | out_valid, out_ready| digest_word, word_index, last_word
//
// a word that does not close a block leaves the unit idle
// the 16th word keeps the unit busy for the 48 steps of the shared step unit, one
// per cycle, then for the feed-forward add in the fold state
// reset loads the MD4 initial chaining values and clears the word position
// the digest sits in its own buffer, so the next message is taken while it
// drains; only a word at the last block slot waits until the digest is gone
// ----------------------------------------------------------------------------
module md4_block_compressor_unit import md4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] message_word,
	input  logic        start_of_message,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	md4_cmd_t cmd;

	// sequencing
	md4_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.start_of_message (start_of_message),
		.end_of_message   (end_of_message),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.word_index       (word_index),
		.last_word        (last_word),
		.cmd              (cmd)
	);

	// hashing datapath
	md4_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_word (message_word),
		.digest_word  (digest_word)
	);

endmodule
